// ===== hw/rtl/record_exchange_sorter_macros.svh =====
// assertion macros used by the record exchange sorter datapath
`ifndef RECORD_EXCHANGE_SORTER_MACROS_SVH
`define RECORD_EXCHANGE_SORTER_MACROS_SVH

// same-cycle implication, checked on clk, off while rst_n is low
`define RSE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk, off while rst_n is low
`define RSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/rse_pkg.sv =====
// shared types, constants and the name canonicalizer of the record sorter
`default_nettype none

package rse_pkg;

  localparam int ROLL_W     = 16;
  localparam int NAME_W     = 64;
  localparam int SCORE_W    = 14;
  localparam int KEY_W      = 2;
  localparam int NAME_BYTES = 8;

  localparam logic [KEY_W-1:0] KEY_NONE  = 2'd0;
  localparam logic [KEY_W-1:0] KEY_SCORE = 2'd1;
  localparam logic [KEY_W-1:0] KEY_NAME  = 2'd2;

  typedef struct packed {
    logic [ROLL_W-1:0]  roll;
    logic [NAME_W-1:0]  name;
    logic [SCORE_W-1:0] score;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  // controller to datapath: one strobe per phase, none for the emit wait state
  typedef struct packed {
    logic idle;
    logic head;
    logic first;
    logic run;
    logic tail;
    logic emit_rd;
    logic emit_ld;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_xfer;
    logic in_last;
    logic sort_go;
    logic run_done;
    logic more_rows;
    logic out_xfer;
    logic emit_done;
  } dp_sts_t;

  // keep the top NAME_BYTES bytes, cut at the first zero byte
  function automatic logic [NAME_W-1:0] canon_name(input logic [NAME_W-1:0] raw);
    logic [NAME_W-1:0] res;
    logic              alive;
    logic [7:0]        byte_v;
    res   = '0;
    alive = 1'b1;
    for (int b = 0; b < 8; b++) begin
      byte_v = raw[NAME_W-1-8*b -: 8];
      if (b >= NAME_BYTES || byte_v == 8'd0) alive = 1'b0;
      if (alive) res[NAME_W-1-8*b -: 8] = byte_v;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rse_if.sv =====
// valid/ready channel interfaces for record input and sorted output
`default_nettype none

interface rse_in_if;
  import rse_pkg::*;
  logic               valid;
  logic               ready;
  logic [ROLL_W-1:0]  roll_number;
  logic [NAME_W-1:0]  name_chars;
  logic [SCORE_W-1:0] percentage;
  logic               last_record;

  modport source (output valid, roll_number, name_chars, percentage, last_record,
                  input ready);
  modport sink   (input valid, roll_number, name_chars, percentage, last_record,
                  output ready);
endinterface

interface rse_out_if;
  import rse_pkg::*;
  logic               valid;
  logic               ready;
  logic [ROLL_W-1:0]  out_roll_number;
  logic [NAME_W-1:0]  out_name_chars;
  logic [SCORE_W-1:0] out_percentage;
  logic               out_last;
  logic               overflow_flag;

  modport source (output valid, out_roll_number, out_name_chars, out_percentage,
                  out_last, overflow_flag, input ready);
  modport sink   (input valid, out_roll_number, out_name_chars, out_percentage,
                  out_last, overflow_flag, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rse_ram.sv =====
// generic single-write single-read ram with registered read data
`default_nettype none

module rse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_addr] <= wr_data;
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== hw/rtl/rse_ctrl.sv =====
// phase sequencer for load, exchange sort and emission
`default_nettype none

module rse_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  rse_pkg::dp_sts_t sts,
  output rse_pkg::dp_cmd_t cmd
);
  import rse_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_HEAD    = 8'b0000_0010,
    S_FIRST   = 8'b0000_0100,
    S_RUN     = 8'b0000_1000,
    S_TAIL    = 8'b0001_0000,
    S_EMIT_RD = 8'b0010_0000,
    S_EMIT_LD = 8'b0100_0000,
    S_EMIT_WT = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (sts.in_xfer && sts.in_last) state_nxt = sts.sort_go ? S_HEAD : S_EMIT_RD;
      end
      S_HEAD:    state_nxt = S_FIRST;
      S_FIRST:   state_nxt = S_RUN;
      S_RUN: begin
        if (sts.run_done) state_nxt = S_TAIL;
      end
      S_TAIL:    state_nxt = sts.more_rows ? S_HEAD : S_EMIT_RD;
      S_EMIT_RD: state_nxt = S_EMIT_LD;
      S_EMIT_LD: state_nxt = S_EMIT_WT;
      S_EMIT_WT: begin
        if (sts.out_xfer) state_nxt = sts.emit_done ? S_IDLE : S_EMIT_RD;
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd         = '0;
    cmd.idle    = (state_r == S_IDLE);
    cmd.head    = (state_r == S_HEAD);
    cmd.first   = (state_r == S_FIRST);
    cmd.run     = (state_r == S_RUN);
    cmd.tail    = (state_r == S_TAIL);
    cmd.emit_rd = (state_r == S_EMIT_RD);
    cmd.emit_ld = (state_r == S_EMIT_LD);
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rse_dp.sv =====
// record store, counters, compare/swap datapath and output register
`default_nettype none
`include "record_exchange_sorter_macros.svh"

module rse_dp #(
  parameter int MAX_RECORDS = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [rse_pkg::KEY_W-1:0] cfg_wr_data,
  input  rse_pkg::dp_cmd_t         cmd,
  output rse_pkg::dp_sts_t         sts,
  rse_in_if.sink                   in_rec,
  rse_out_if.source                out_rec
);
  import rse_pkg::*;

  localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int CW = $clog2(MAX_RECORDS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_RECORDS);

  logic [KEY_W-1:0] key_r;
  logic [CW-1:0]    cnt_r;
  logic             drop_r;
  logic [AW-1:0]    i_r;
  logic [AW-1:0]    j_r;
  logic [AW-1:0]    k_r;
  rec_t             cur_r;
  logic             out_vld_r;
  rec_t             out_q_r;
  logic             out_last_r;
  logic             out_ovf_r;

  logic             in_xfer;
  logic             out_xfer;
  logic             has_room;
  logic [CW-1:0]    n_after;
  logic             key_ok;
  logic             gt;
  logic             emit_done;
  rec_t             in_w;
  rec_t             rd_rec;
  logic [REC_W-1:0] ram_q;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  rec_t             wr_rec;
  logic [AW-1:0]    rd_addr;

  assign in_rec.ready = cmd.idle;
  assign in_xfer      = in_rec.valid & in_rec.ready;
  assign out_xfer     = out_vld_r & out_rec.ready;
  assign has_room     = (cnt_r < MAX_CNT);
  assign n_after      = cnt_r + CW'(has_room);
  assign key_ok       = (key_r == KEY_SCORE) || (key_r == KEY_NAME);
  assign emit_done    = ((CW'(k_r) + CW'(1)) == cnt_r);

  assign in_w.roll  = in_rec.roll_number;
  assign in_w.name  = canon_name(in_rec.name_chars);
  assign in_w.score = in_rec.percentage;
  assign rd_rec     = rec_t'(ram_q);

  // held record at row i against the record just read at column j
  always_comb begin
    case (key_r)
      KEY_SCORE: gt = (cur_r.score > rd_rec.score);
      KEY_NAME:  gt = (cur_r.name > rd_rec.name);
      default:   gt = 1'b0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt_r[AW-1:0];
    wr_rec  = in_w;
    if (in_xfer && has_room) begin
      wr_en = 1'b1;
    end else if (cmd.run && gt) begin
      wr_en   = 1'b1;
      wr_addr = j_r;
      wr_rec  = cur_r;
    end else if (cmd.tail) begin
      wr_en   = 1'b1;
      wr_addr = i_r;
      wr_rec  = cur_r;
    end
  end

  always_comb begin
    rd_addr = k_r;
    if (cmd.head)       rd_addr = i_r;
    else if (cmd.first) rd_addr = j_r;
    else if (cmd.run)   rd_addr = j_r + AW'(1);
  end

  rse_ram #(
    .WIDTH (REC_W),
    .DEPTH (MAX_RECORDS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (REC_W'(wr_rec)),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r     <= KEY_NONE;
      cnt_r     <= '0;
      drop_r    <= 1'b0;
      i_r       <= '0;
      j_r       <= '0;
      k_r       <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_wr_en) key_r <= cfg_wr_data;
      if (in_xfer) begin
        if (has_room) cnt_r <= cnt_r + CW'(1);
        else          drop_r <= 1'b1;
        i_r <= '0;
        k_r <= '0;
      end
      if (cmd.head) j_r <= i_r + AW'(1);
      if (cmd.run)  j_r <= j_r + AW'(1);
      if (cmd.tail) i_r <= i_r + AW'(1);
      if (cmd.emit_ld) out_vld_r <= 1'b1;
      if (out_xfer) begin
        out_vld_r <= 1'b0;
        if (emit_done) begin
          cnt_r  <= '0;
          drop_r <= 1'b0;
        end else begin
          k_r <= k_r + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.first || (cmd.run && gt)) cur_r <= rd_rec;
    if (cmd.emit_ld) begin
      out_q_r    <= rd_rec;
      out_last_r <= emit_done;
      out_ovf_r  <= drop_r;
    end
  end

  assign out_rec.valid           = out_vld_r;
  assign out_rec.out_roll_number = out_q_r.roll;
  assign out_rec.out_name_chars  = out_q_r.name;
  assign out_rec.out_percentage  = out_q_r.score;
  assign out_rec.out_last        = out_last_r;
  assign out_rec.overflow_flag   = out_ovf_r;

  always_comb begin
    sts           = '0;
    sts.in_xfer   = in_xfer;
    sts.in_last   = in_rec.last_record;
    sts.sort_go   = key_ok && (n_after >= CW'(2));
    sts.run_done  = ((CW'(j_r) + CW'(1)) == cnt_r);
    sts.more_rows = ((CW'(i_r) + CW'(2)) < cnt_r);
    sts.out_xfer  = out_xfer;
    sts.emit_done = emit_done;
  end

  `RSE_ASSERT_IMPL(a_drop_only_full, drop_r, cnt_r == MAX_CNT, "drop flag set with room left")
  `RSE_ASSERT_IMPL(a_col_after_row, cmd.run, j_r > i_r, "compare column not past row")
  `RSE_ASSERT_IMPL(a_no_load_in_emit, out_vld_r, !in_rec.ready, "input open during emission")
  `RSE_ASSERT_IMPL(a_emit_rd_empty, cmd.emit_rd, !out_vld_r, "output valid during record read")
  `RSE_ASSERT_NEXT(a_set_cleared, out_xfer && out_last_r, (cnt_r == '0) && !drop_r, "set not cleared")

endmodule

`default_nettype wire

// ===== hw/rtl/record_exchange_sorter.sv =====
// top level of the record exchange sorter
`default_nettype none

// Collects up to MAX_RECORDS records (roll number, eight-byte name, percentage
// in hundredths) over in_rec, one transfer per cycle while the block is open
// for input. Names are stored canonically: bytes after the first zero byte
// are cleared. Records beyond capacity are dropped and flagged on every output
// of the set. The record with last_record set closes the set, even if it was
// itself dropped. With sort_key 1 (percentage) or 2 (name, unsigned byte
// order) the stored set is then sorted ascending by exchange sort: row i is
// held in a register while columns i+1..n-1 stream out of the record RAM one
// per cycle, and a larger held record is swapped into the column. Equal keys
// never swap; sort_key 0 or 3 keeps load order. Each row passes through head,
// first read, column run and tail states, paced by the single read port of
// the record RAM. Emission then reads, loads and presents each record on
// out_rec, waiting for its transfer before the next read, out_last marking
// the final one; no new record is taken until the last output transfer.
// There is no clearing pass after reset. sort_key is written through
// cfg_wr_en/cfg_wr_data and must only change while the block is idle.
module record_exchange_sorter #(
  parameter int MAX_RECORDS = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [rse_pkg::KEY_W-1:0] cfg_wr_data,
  rse_in_if.sink                    in_rec,
  rse_out_if.source                 out_rec
);
  import rse_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // phase sequencing: idle/load, row head, first read, column run, row tail, emit
  rse_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  // record ram, sort counters, compare/swap and the output register
  rse_dp #(
    .MAX_RECORDS (MAX_RECORDS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts),
    .in_rec      (in_rec),
    .out_rec     (out_rec)
  );

endmodule

`default_nettype wire
